### design/atcm_pkg.sv
// ----------------------------------------------------------------------------
// atcm_pkg
// Shared types, character constants and default sizes for the AT command
// line matcher.
// ----------------------------------------------------------------------------
package atcm_pkg;

    // default sizes
    localparam int LINE_SIZE_DEF  = 128;
    localparam int MAX_NAMES_DEF  = 16;
    localparam int NAME_CHARS_DEF = 16;

    // line framing
    localparam int         HDR_LEN = 3;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_PLUS = 8'h2B;

    // result of one table scan
    typedef struct packed {
        logic       status;      // 1 unknown command
        logic [3:0] index;
        logic       with_arg;
    } t_match_res;

    // top level control
    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_SCAN = 3'b010,
        C_EMIT = 3'b100
    } t_ctl_state;

    // scan sequencer
    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_READ = 3'b010,
        M_CMP  = 3'b100
    } t_scan_state;

    // expected header character at a header position
    function automatic logic [7:0] hdr_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = CH_A;
            2'd1:    c = CH_T;
            2'd2:    c = CH_PLUS;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### design/atcm_ram.sv
// ----------------------------------------------------------------------------
// atcm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module atcm_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 128,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/atcm_match.sv
// ----------------------------------------------------------------------------
// atcm_match
// Table scan sequencer: walks the name table row by row and character by
// character through one shared byte compare, a read state and a compare state per character.
// ----------------------------------------------------------------------------
module atcm_match #(
    parameter int  LINE_SIZE  = atcm_pkg::LINE_SIZE_DEF,
    parameter int  MAX_NAMES  = atcm_pkg::MAX_NAMES_DEF,
    parameter int  NAME_CHARS = atcm_pkg::NAME_CHARS_DEF,
    localparam int FW   = $clog2(LINE_SIZE),
    localparam int NA_W = (MAX_NAMES * NAME_CHARS > 1) ? $clog2(MAX_NAMES * NAME_CHARS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [FW-1:0]        i_body_len,
    input  logic [4:0]           i_count,
    input  logic [7:0]           i_name_char,
    input  logic [7:0]           i_line_char,
    output logic [NA_W-1:0]      o_name_addr,
    output logic [FW-1:0]        o_line_addr,
    output logic                 o_done,
    output atcm_pkg::t_match_res o_res
);
    import atcm_pkg::*;

    localparam int KW  = $clog2(NAME_CHARS + 1);
    localparam int RW  = $clog2(MAX_NAMES + 1);
    localparam int MW  = (KW > FW) ? KW : FW;
    localparam int CMW = (RW > 5) ? RW : 5;

    t_scan_state      r_state, n_state;
    logic [KW-1:0]    r_k, n_k;
    logic [RW-1:0]    r_row, n_row;
    logic [NA_W-1:0]  r_base, n_base;
    logic [FW-1:0]    r_body_len;
    logic [CMW-1:0]   r_count_eff;

    logic [7:0]       w_char;
    logic             w_k_lt;
    logic             w_k_eq;
    logic             w_row_end;

    // addresses follow the scan position
    assign o_name_addr = NA_W'(32'(r_base) + 32'(r_k));
    assign o_line_addr = FW'(32'(r_k) + HDR_LEN);

    // name character, end of row reads as terminator
    assign w_char    = (32'(r_k) == NAME_CHARS) ? 8'h00 : i_name_char;
    assign w_k_lt    = MW'(r_k) < MW'(r_body_len);
    assign w_k_eq    = MW'(r_k) == MW'(r_body_len);
    assign w_row_end = CMW'(r_row) >= r_count_eff;

    // sequencer next state and result
    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_row    = r_row;
        n_base   = r_base;
        o_done   = 1'b0;
        o_res    = '{status: 1'b1, index: 4'd0, with_arg: 1'b0};
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_state = M_READ;
                    n_k     = '0;
                    n_row   = '0;
                    n_base  = '0;
                end
            end
            M_READ: begin
                if (w_row_end) begin
                    o_done  = 1'b1;
                    n_state = M_IDLE;
                end else begin
                    n_state = M_CMP;
                end
            end
            M_CMP: begin
                n_state = M_READ;
                if (w_char == 8'h00) begin
                    // name ended: exact or name-then-equals form
                    if (w_k_eq || (w_k_lt && i_line_char == CH_EQ)) begin
                        o_done   = 1'b1;
                        o_res    = '{status: 1'b0, index: 4'(r_row), with_arg: !w_k_eq};
                        n_state  = M_IDLE;
                    end else begin
                        n_row  = r_row + 1'b1;
                        n_base = NA_W'(32'(r_base) + NAME_CHARS);
                        n_k    = '0;
                    end
                end else if (w_k_lt && i_line_char == w_char) begin
                    n_k = r_k + 1'b1;
                end else begin
                    n_row  = r_row + 1'b1;
                    n_base = NA_W'(32'(r_base) + NAME_CHARS);
                    n_k    = '0;
                end
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_k    <= n_k;
        r_row  <= n_row;
        r_base <= n_base;
    end

    // line length and table size captured at start
    always_ff @(posedge i_clk) begin
        if (r_state == M_IDLE && i_start) begin
            r_body_len  <= i_body_len;
            r_count_eff <= (CMW'(i_count) > CMW'(MAX_NAMES)) ? CMW'(MAX_NAMES)
                                                               : CMW'(i_count);
        end
    end

endmodule

### design/at_command_line_matcher.sv
// ----------------------------------------------------------------------------
// at_command_line_matcher
// Collects received bytes into a line store, checks the "AT+" header and at
// CR LF matches the command body against a table of registered names.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries either a received byte
// (i_command = 0) or one name character for the table (i_command = 1).
// Output channel (o_out_valid / i_out_ready) carries one result per
// completed line: status, first matching index, argument form, body length.
// i_cfg_we writes command_count (number of table entries in use).
// A byte that completes a line starts a scan of the name table, in which
// each compared character takes a read of the name and line RAMs and then
// a compare; the registered read port of the name RAM sets this pace. The
// input is not ready during a scan or while a result waits to be placed.
// The result sits in an output register; if the receiver stalls, the next
// line result waits until the register is taken and the input stays not
// ready meanwhile; received bytes that complete no line are still accepted.
// Reset empties the line, clears command_count and the output register;
// the name table holds no defined contents until written.
// ----------------------------------------------------------------------------
module at_command_line_matcher #(
    parameter int LINE_SIZE  = atcm_pkg::LINE_SIZE_DEF,
    parameter int MAX_NAMES  = atcm_pkg::MAX_NAMES_DEF,
    parameter int NAME_CHARS = atcm_pkg::NAME_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_command,
    input  logic [7:0] i_data_byte,
    input  logic [3:0] i_entry,
    input  logic [3:0] i_char_position,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_status,
    output logic [3:0] o_command_index,
    output logic       o_with_argument,
    output logic [6:0] o_body_length,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data
);
    import atcm_pkg::*;

    localparam int FW   = $clog2(LINE_SIZE);
    localparam int NA_W = (MAX_NAMES * NAME_CHARS > 1) ? $clog2(MAX_NAMES * NAME_CHARS) : 1;

    t_ctl_state      r_state, n_state;
    logic [FW-1:0]   r_fill, n_fill;
    logic            r_line_open, n_line_open;
    logic            r_hdr_ok, n_hdr_ok;
    logic            r_prev_cr, n_prev_cr;
    logic [FW-1:0]   r_body_len;
    logic [4:0]      r_cmd_count;
    t_match_res      r_res;
    logic            r_out_valid;
    logic            r_status;
    logic [3:0]      r_index;
    logic            r_with_arg;
    logic [6:0]      r_out_len;

    logic            w_in_xfer;
    logic            w_rx_byte;
    logic            w_full;
    logic            w_store;
    logic            w_hdr_match;
    logic            w_start;
    logic [FW-1:0]   w_body_len;
    logic            w_tab_we;
    logic [NA_W-1:0] w_tab_addr;
    logic [NA_W-1:0] w_name_raddr;
    logic [FW-1:0]   w_line_raddr;
    logic [7:0]      w_name_char;
    logic [7:0]      w_line_char;
    logic            w_done;
    t_match_res      w_res;
    logic            w_out_free;

    // input transfer decode
    assign o_in_ready  = (r_state == C_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_rx_byte   = w_in_xfer && !i_command;
    assign w_full      = 32'(r_fill) >= LINE_SIZE - 1;
    assign w_store     = w_rx_byte && !w_full;
    assign w_hdr_match = (r_fill == '0 || r_hdr_ok) && (i_data_byte == hdr_char(r_fill[1:0]));
    assign w_body_len  = r_fill - FW'(4);
    assign w_out_free  = !r_out_valid || i_out_ready;

    // name table write address, out of range writes dropped
    assign w_tab_we   = w_in_xfer && i_command && (32'(i_entry) < MAX_NAMES)
                        && (32'(i_char_position) < NAME_CHARS);
    assign w_tab_addr = NA_W'(32'(i_entry) * NAME_CHARS + 32'(i_char_position));

    // line store
    atcm_ram #(
        .WIDTH (8),
        .DEPTH (LINE_SIZE)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_fill),
        .i_wdata (i_data_byte),
        .i_raddr (w_line_raddr),
        .o_rdata (w_line_char)
    );

    // name table
    atcm_ram #(
        .WIDTH (8),
        .DEPTH (MAX_NAMES * NAME_CHARS)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (w_tab_addr),
        .i_wdata (i_data_byte),
        .i_raddr (w_name_raddr),
        .o_rdata (w_name_char)
    );

    // table scan sequencer
    atcm_match #(
        .LINE_SIZE  (LINE_SIZE),
        .MAX_NAMES  (MAX_NAMES),
        .NAME_CHARS (NAME_CHARS)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_body_len  (w_body_len),
        .i_count     (r_cmd_count),
        .i_name_char (w_name_char),
        .i_line_char (w_line_char),
        .o_name_addr (w_name_raddr),
        .o_line_addr (w_line_raddr),
        .o_done      (w_done),
        .o_res       (w_res)
    );

    // line assembly and control
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_line_open = r_line_open;
        n_hdr_ok    = r_hdr_ok;
        n_prev_cr   = r_prev_cr;
        w_start     = 1'b0;
        case (r_state)
            C_IDLE: begin
                if (w_rx_byte) begin
                    if (w_full) begin
                        // overflow: drop byte, empty the line
                        n_fill      = '0;
                        n_line_open = 1'b0;
                    end else begin
                        n_fill    = r_fill + 1'b1;
                        n_prev_cr = (i_data_byte == CH_CR);
                        if (!r_line_open) begin
                            n_hdr_ok = w_hdr_match;
                            if (32'(r_fill) == HDR_LEN - 1) begin
                                if (w_hdr_match) begin
                                    n_line_open = 1'b1;
                                end else begin
                                    n_fill = '0;
                                end
                            end
                        end else if (32'(r_fill) >= HDR_LEN + 1 && r_prev_cr
                                     && i_data_byte == CH_LF) begin
                            // line complete: start the table scan
                            w_start     = 1'b1;
                            n_fill      = '0;
                            n_line_open = 1'b0;
                            n_state     = C_SCAN;
                        end
                    end
                end
            end
            C_SCAN: begin
                if (w_done) begin
                    n_state = C_EMIT;
                end
            end
            C_EMIT: begin
                if (w_out_free) begin
                    n_state = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_IDLE;
            r_fill      <= '0;
            r_line_open <= 1'b0;
            r_hdr_ok    <= 1'b0;
            r_prev_cr   <= 1'b0;
            r_cmd_count <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_line_open <= n_line_open;
            r_hdr_ok    <= n_hdr_ok;
            r_prev_cr   <= n_prev_cr;
            if (i_cfg_we) begin
                r_cmd_count <= i_cfg_data;
            end
        end
    end

    // body length and scan result holding
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_body_len <= w_body_len;
        end
        if (r_state == C_SCAN && w_done) begin
            r_res <= w_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == C_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_EMIT && w_out_free) begin
            r_status   <= r_res.status;
            r_index    <= r_res.index;
            r_with_arg <= r_res.with_arg;
            r_out_len  <= 7'(r_body_len);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_command_index = r_index;
    assign o_with_argument = r_with_arg;
    assign o_body_length   = r_out_len;

    // fill count never reaches the store size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) < LINE_SIZE)
        else $error("line fill count out of range");

    // before the header is accepted at most two bytes are held
    a_hdr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_line_open |-> 32'(r_fill) < HDR_LEN)
        else $error("line held without header");

    // scan completion only while scanning
    a_done_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == C_SCAN)
        else $error("scan done outside scan phase");

    // a result appears only after a scan has finished
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == C_EMIT))
        else $error("result transfer without a finished scan");

endmodule

### verif/atcm_result_checker.sv
// ----------------------------------------------------------------------------
// atcm_result_checker
// Watches the input, result and register ports of the AT command line
// matcher. Keeps its own line store, name table and command count, works out
// the result of each completed line and compares every result transfer with
// the oldest outstanding one. Hands the failure count and the number of
// outstanding results to the testbench top.
// ----------------------------------------------------------------------------
package atcm_tb_pkg;

    // input transfer kinds
    localparam logic CMD_RX_BYTE   = 1'b0;
    localparam logic CMD_NAME_CHAR = 1'b1;

    // result status codes
    localparam logic STATUS_MATCHED = 1'b0;
    localparam logic STATUS_UNKNOWN = 1'b1;

    // one line result as seen on the result port
    typedef struct packed {
        logic       status;
        logic [3:0] index;
        logic       with_arg;
        logic [6:0] body_len;
    } t_line_result;

endpackage

module atcm_result_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_command,
    input  logic [7:0] i_data_byte,
    input  logic [3:0] i_entry,
    input  logic [3:0] i_char_position,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_status,
    input  logic [3:0] i_command_index,
    input  logic       i_with_argument,
    input  logic [6:0] i_body_length,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import atcm_pkg::*;
    import atcm_tb_pkg::*;

    localparam int LINE_SIZE  = LINE_SIZE_DEF;
    localparam int MAX_NAMES  = MAX_NAMES_DEF;
    localparam int NAME_CHARS = NAME_CHARS_DEF;

    typedef enum logic [1:0] {
        MATCH_NONE,
        MATCH_EXACT,
        MATCH_ARG
    } t_match_kind;

    logic [7:0]   line_buf [LINE_SIZE];
    int           fill_level;
    logic         line_open;
    logic [7:0]   name_rom [MAX_NAMES][NAME_CHARS];
    int           active_names;
    t_line_result pending_results [$];

    // a name ends at its first zero byte, a full row has no terminator
    function automatic int name_length(input int row);
        int nlen;
        nlen = NAME_CHARS;
        for (int k = NAME_CHARS - 1; k >= 0; k--)
            if (name_rom[row][k] == 8'h00) nlen = k;
        return nlen;
    endfunction

    // body equal to the name, or name followed by '='
    function automatic t_match_kind row_match(input int row, input int body_len);
        int          nlen;
        t_match_kind kind;
        nlen = name_length(row);
        kind = MATCH_NONE;
        if (nlen <= body_len) begin
            kind = MATCH_EXACT;
            for (int k = 0; k < nlen; k++)
                if (line_buf[HDR_LEN + k] != name_rom[row][k]) kind = MATCH_NONE;
            if (kind == MATCH_EXACT && nlen != body_len)
                kind = (line_buf[HDR_LEN + nlen] == CH_EQ) ? MATCH_ARG : MATCH_NONE;
        end
        return kind;
    endfunction

    // append one received byte and work out the line result at cr lf
    task automatic absorb_rx_byte(input logic [7:0] rx);
        t_line_result res;
        t_match_kind  kind;
        int           body_len;
        int           rows;
        if (fill_level >= LINE_SIZE - 1) begin
            // full store drops the byte and starts over
            fill_level = 0;
            line_open  = 1'b0;
        end else begin
            line_buf[fill_level] = rx;
            fill_level++;
            // header check once three bytes are held
            if (!line_open && fill_level >= HDR_LEN) begin
                if (line_buf[0] == CH_A && line_buf[1] == CH_T && line_buf[2] == CH_PLUS)
                    line_open = 1'b1;
                else
                    fill_level = 0;
            end
            if (line_open && fill_level >= HDR_LEN + 2 &&
                line_buf[fill_level - 2] == CH_CR && line_buf[fill_level - 1] == CH_LF) begin
                body_len     = fill_level - HDR_LEN - 2;
                rows         = (active_names > MAX_NAMES) ? MAX_NAMES : active_names;
                res.status   = STATUS_UNKNOWN;
                res.index    = '0;
                res.with_arg = 1'b0;
                res.body_len = body_len[6:0];
                // scan from the back so the first matching row wins
                for (int row = rows - 1; row >= 0; row--) begin
                    kind = row_match(row, body_len);
                    if (kind != MATCH_NONE) begin
                        res.status   = STATUS_MATCHED;
                        res.index    = row[3:0];
                        res.with_arg = (kind == MATCH_ARG);
                    end
                end
                pending_results.push_back(res);
                fill_level = 0;
                line_open  = 1'b0;
            end
        end
    endtask

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t checker: %s mismatch, expected %0d actual %0d",
                     $time, what, want, got);
            o_fail_count++;
        end
    endtask

    // result transfers are checked before the input transfer of the same edge
    always @(posedge i_clk) begin
        t_line_result want;
        if (!i_rst_n) begin
            fill_level   = 0;
            line_open    = 1'b0;
            active_names = 0;
            o_fail_count = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) active_names = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t checker: unexpected result, expected none actual %0d %0d %0d %0d",
                             $time, i_status, i_command_index, i_with_argument, i_body_length);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("status", want.status, i_status);
                    compare_field("command_index", want.index, i_command_index);
                    compare_field("with_argument", want.with_arg, i_with_argument);
                    compare_field("body_length", want.body_len, i_body_length);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_command == CMD_NAME_CHAR) begin
                    if (i_entry < MAX_NAMES && i_char_position < NAME_CHARS)
                        name_rom[i_entry][i_char_position] = i_data_byte;
                end else begin
                    absorb_rx_byte(i_data_byte);
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

### verif/tb_at_command_line_matcher.sv
// ----------------------------------------------------------------------------
// tb_at_command_line_matcher
// Drives the AT command line matcher with name table loads, directed lines
// for the header, framing, overflow and matching corner cases, then random
// lines and table writes under several command counts and stall patterns.
// The checker beside the block predicts and compares; this top only makes
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_at_command_line_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    import atcm_pkg::*;
    import atcm_tb_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 200;
    localparam int SEGMENTS      = 5;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic       command       = CMD_RX_BYTE;
    logic [7:0] data_byte     = 8'h00;
    logic [3:0] entry         = 4'h0;
    logic [3:0] char_position = 4'h0;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic       status;
    logic [3:0] command_index;
    logic       with_argument;
    logic [6:0] body_length;
    logic       cfg_we        = 1'b0;
    logic [4:0] cfg_data      = 5'd0;
    int         fail_count;
    int         pending;

    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         items_sent    = 0;
    logic [7:0] shadow_names [16][16];
    logic [7:0] line_body [$];

    at_command_line_matcher u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_command       (command),
        .i_data_byte     (data_byte),
        .i_entry         (entry),
        .i_char_position (char_position),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_status        (status),
        .o_command_index (command_index),
        .o_with_argument (with_argument),
        .o_body_length   (body_length),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data)
    );

    atcm_result_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_command       (command),
        .i_data_byte     (data_byte),
        .i_entry         (entry),
        .i_char_position (char_position),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_status        (status),
        .i_command_index (command_index),
        .i_with_argument (with_argument),
        .i_body_length   (body_length),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver stalls
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one input transfer, with random gaps before it
    task automatic send_item(input logic cmd, input logic [7:0] val,
                             input logic [3:0] ent, input logic [3:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        data_byte     <= val;
        entry         <= ent;
        char_position <= pos;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (cmd == CMD_NAME_CHAR) shadow_names[ent][pos] = val;
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] val);
        send_item(CMD_RX_BYTE, val, 4'($urandom_range(15)), 4'($urandom_range(15)));
    endtask

    // whole row: name characters, then zeros
    task automatic write_name(input int row, input string s);
        for (int k = 0; k < 16; k++)
            send_item(CMD_NAME_CHAR, (k < s.len()) ? s[k] : 8'h00, row[3:0], k[3:0]);
    endtask

    task automatic load_body(input string s);
        line_body.delete();
        for (int k = 0; k < s.len(); k++) line_body.push_back(s[k]);
    endtask

    // header, queued body, cr lf
    task automatic send_line();
        send_byte(CH_A);
        send_byte(CH_T);
        send_byte(CH_PLUS);
        for (int k = 0; k < line_body.size(); k++) send_byte(line_body[k]);
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // wait until every result is in and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_command_count(input logic [4:0] val);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] rand_letter();
        return 8'(CH_A + $urandom_range(25));
    endfunction

    task automatic queue_row_name(input int row);
        line_body.delete();
        for (int k = 0; k < 16; k++)
            if (shadow_names[row][k] != 8'h00 && line_body.size() == k)
                line_body.push_back(shadow_names[row][k]);
    endtask

    // mostly well-formed lines built from table names, plus noise
    task automatic send_random_sequence();
        int roll;
        int n;
        roll = $urandom_range(99);
        if (roll < 55) begin
            queue_row_name($urandom_range(15));
            case ($urandom_range(3))
                0: ;
                1: begin
                    line_body.push_back(CH_EQ);
                    n = $urandom_range(8);
                    repeat (n) line_body.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end
                2: begin
                    if (line_body.size() > 0)
                        line_body[$urandom_range(line_body.size() - 1)] = rand_letter();
                    else
                        line_body.push_back(CH_EQ);
                end
                default: line_body.push_back(rand_letter());
            endcase
            send_line();
        end else if (roll < 70) begin
            // random bytes, zeros and high bytes included
            line_body.delete();
            n = $urandom_range(10);
            repeat (n) line_body.push_back(8'($urandom_range(255)));
            send_line();
        end else if (roll < 78) begin
            // three bytes with a broken header
            case ($urandom_range(2))
                0: begin send_byte(CH_A); send_byte(CH_T); send_byte(rand_letter()); end
                1: begin send_byte(CH_A); send_byte(rand_letter()); send_byte(CH_PLUS); end
                default: begin
                    send_byte(8'($urandom_range(255)));
                    send_byte(CH_T);
                    send_byte(CH_PLUS);
                end
            endcase
        end else if (roll < 83) begin
            // long line, the longest one overflows on its lf
            queue_row_name($urandom_range(15));
            line_body.push_back(CH_EQ);
            n = $urandom_range(100, 123);
            while (line_body.size() < n) line_body.push_back(rand_letter());
            send_line();
        end else begin
            // table rewrites
            n = $urandom_range(1, 4);
            repeat (n) begin
                case ($urandom_range(3))
                    0: send_item(CMD_NAME_CHAR, rand_letter(),
                                 4'($urandom_range(15)), 4'($urandom_range(15)));
                    1: send_item(CMD_NAME_CHAR, 8'h00,
                                 4'($urandom_range(15)), 4'($urandom_range(15)));
                    2: send_item(CMD_NAME_CHAR, CH_EQ,
                                 4'($urandom_range(15)), 4'($urandom_range(15)));
                    default: send_item(CMD_NAME_CHAR, 8'($urandom_range(255)),
                                       4'($urandom_range(15)), 4'($urandom_range(15)));
                endcase
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        int random_start;
        int done_items;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 12;
        recv_idle_pct = 58;

        // full table load so no scan ever reads an unwritten character
        write_name(0, "CGMI");
        write_name(1, "CGM");
        write_name(2, "");
        write_name(3, "CSQ");
        write_name(4, "CREG");
        write_name(5, "CGMR");
        write_name(6, "ATI");
        write_name(7, "CMGF");
        write_name(8, "CMGS");
        write_name(9, "CPIN");
        write_name(10, "RST");
        write_name(11, "GMR");
        write_name(12, "CSQX");
        write_name(13, "ABCDEFGHIJKLMNOP");
        write_name(14, "E");
        write_name(15, "CGMIX");

        // no names in use: always unknown
        load_body("CGMI");
        send_line();

        set_command_count(5'd16);
        load_body("CGMI");
        send_line();
        load_body("CGM=1,2");
        send_line();
        // empty body hits the empty name
        load_body("");
        send_line();
        load_body("=5");
        send_line();
        // name filling a whole row
        load_body("ABCDEFGHIJKLMNOP");
        send_line();
        load_body("CGMIX");
        send_line();
        load_body("CGMR");
        send_line();
        load_body("CGMI=3");
        send_line();
        load_body("E=");
        send_line();
        load_body("XYZ");
        send_line();
        // bad headers
        send_byte(CH_A);
        send_byte(8'h58);
        send_byte(CH_PLUS);
        send_byte(CH_A);
        send_byte(CH_T);
        send_byte(CH_T);
        // zero and all-ones bytes inside the body
        load_body("CSQ");
        line_body.push_back(8'h00);
        line_body.push_back(8'hFF);
        send_line();
        // lone cr inside the body
        load_body("A");
        line_body.push_back(CH_CR);
        line_body.push_back(8'h42);
        send_line();
        // longest body that still fits
        load_body("CSQ=");
        while (line_body.size() < 122) line_body.push_back(8'h78);
        send_line();
        // full store: last byte dropped and line abandoned
        send_byte(CH_A);
        send_byte(CH_T);
        send_byte(CH_PLUS);
        repeat (125) send_byte(8'h5A);
        load_body("CSQ");
        send_line();

        // random part in segments with different command counts
        random_start = items_sent;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: set_command_count(5'd31);
                1: set_command_count(5'd1);
                2: set_command_count(5'd0);
                3: set_command_count(5'($urandom_range(2, 15)));
                default: set_command_count(5'd16);
            endcase
            while (items_sent - random_start < (seg + 1) * RANDOM_ITEMS / SEGMENTS) begin
                done_items = items_sent - random_start;
                if (done_items < RANDOM_ITEMS / 3) begin
                    send_idle_pct = 12;
                    recv_idle_pct = 58;
                end else if (done_items < 2 * RANDOM_ITEMS / 3) begin
                    send_idle_pct = 58;
                    recv_idle_pct = 12;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                send_random_sequence();
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial begin
        #6_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
